/* src/ctcgd_pkg.sv */
// Shared constants and types for the greedy CTC decoder.
`timescale 1ns / 1ps

package ctcgd_pkg;

  localparam int SCORE_BITS  = 16;
  localparam int VALUE_BITS  = 13;
  localparam int MAX_CLASSES = 8192;
  localparam int CNT_BITS    = $clog2(MAX_CLASSES + 1);
  localparam int MAX_ROWS    = 256;
  localparam int SEG_BITS    = $clog2(MAX_ROWS + 1);

  localparam int MAX_RESULTS = 3;
  localparam int PUSH_BITS   = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_BITS    = $clog2(FIFO_DEPTH);
  localparam int FCNT_BITS   = $clog2(FIFO_DEPTH + 1);

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_LEN  = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } result_t;

  // Results produced by one input transaction, in order.
  typedef struct packed {
    logic [PUSH_BITS-1:0]           num;
    result_t [MAX_RESULTS-1:0]      data;
  } push_t;

endpackage

/* src/ctc_greedy_decoder.sv */
// Greedy CTC decoder top level: running argmax per row and result generation.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o  | score_i, row_end_i, seq_end_i
//   out     | output    | out_valid_o / out_stall_i| kind_o, value_o, last_o
//
// One input transaction per cycle while in_stall_o is low; its results are
// computed in the same cycle and enter an eight-entry result queue. The output
// side releases one result per cycle while out_stall_i is low. A row yields up
// to three results; in_stall_o rises when the queue has fewer than three free
// entries. Reset returns to the start of a sequence and empties the queue.
`timescale 1ns / 1ps

module ctc_greedy_decoder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ctcgd_pkg::SCORE_BITS-1:0] score_i,
  input  logic                                  row_end_i,
  input  logic                                  seq_end_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic                                  kind_o,
  output logic [ctcgd_pkg::VALUE_BITS-1:0]      value_o,
  output logic                                  last_o
);
  import ctcgd_pkg::*;

  localparam logic signed [SCORE_BITS-1:0] ScoreMin = {1'b1, {(SCORE_BITS-1){1'b0}}};

  logic signed [SCORE_BITS-1:0] best_score_q, best_score_d;
  logic [VALUE_BITS-1:0]        best_class_q, best_class_d;
  logic [CNT_BITS-1:0]          class_count_q, class_count_d;
  logic [VALUE_BITS-1:0]        prev_class_q, prev_class_d;
  logic                         seen_q, seen_d;
  logic [SEG_BITS-1:0]          seg_rows_q, seg_rows_d;

  logic                  accept;
  logic                  take;
  logic                  gt;
  logic signed [SCORE_BITS-1:0] row_best;
  logic [VALUE_BITS-1:0] row_class;
  logic [SEG_BITS-1:0]   seg_inc;
  logic                  new_char;
  push_t                 push;
  logic [PUSH_BITS-1:0]  n;
  result_t               head;
  logic [FCNT_BITS-1:0]  fifo_count;
  logic                  pop;

  assign in_stall_o = fifo_count > FCNT_BITS'(FIFO_DEPTH - MAX_RESULTS);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    take      = class_count_q < CNT_BITS'(MAX_CLASSES);
    gt        = take && (score_i > best_score_q);
    row_best  = gt ? score_i : best_score_q;
    row_class = gt ? class_count_q[VALUE_BITS-1:0] : best_class_q;
    seg_inc   = (seg_rows_q < SEG_BITS'(MAX_ROWS)) ? seg_rows_q + SEG_BITS'(1) : seg_rows_q;
    new_char  = (row_class != '0) && (row_class != prev_class_q);

    best_score_d  = best_score_q;
    best_class_d  = best_class_q;
    class_count_d = class_count_q;
    prev_class_d  = prev_class_q;
    seen_d        = seen_q;
    seg_rows_d    = seg_rows_q;
    push          = '0;
    n             = '0;

    if (accept) begin
      if (!row_end_i) begin
        best_score_d  = row_best;
        best_class_d  = row_class;
        class_count_d = class_count_q + CNT_BITS'(take);
      end else begin
        best_score_d  = ScoreMin;
        best_class_d  = '0;
        class_count_d = '0;
        seg_rows_d    = seg_inc;
        if (new_char) begin
          if (seen_q) begin
            // close the previous character's segment
            push.data[n] = '{kind: KIND_LEN,
                             value: VALUE_BITS'(seg_inc - SEG_BITS'(1)),
                             last: 1'b0};
            n          = n + PUSH_BITS'(1);
            seg_rows_d = SEG_BITS'(1);
          end
          seen_d       = 1'b1;
          push.data[n] = '{kind: KIND_CHAR, value: row_class, last: 1'b0};
          n            = n + PUSH_BITS'(1);
        end
        prev_class_d = row_class;
        if (seq_end_i) begin
          push.data[n] = '{kind: KIND_LEN, value: VALUE_BITS'(seg_rows_d), last: 1'b1};
          n            = n + PUSH_BITS'(1);
          prev_class_d = '0;
          seen_d       = 1'b0;
          seg_rows_d   = '0;
        end
      end
    end
    push.num = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_score_q  <= ScoreMin;
      best_class_q  <= '0;
      class_count_q <= '0;
      prev_class_q  <= '0;
      seen_q        <= 1'b0;
      seg_rows_q    <= '0;
    end else begin
      best_score_q  <= best_score_d;
      best_class_q  <= best_class_d;
      class_count_q <= class_count_d;
      prev_class_q  <= prev_class_d;
      seen_q        <= seen_d;
      seg_rows_q    <= seg_rows_d;
    end
  end

  assign out_valid_o = fifo_count != '0;
  assign pop         = out_valid_o && !out_stall_i;

  ctcgd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  assign kind_o  = head.kind;
  assign value_o = head.value;
  assign last_o  = head.last;

endmodule

/* src/ctcgd_fifo.sv */
// Result queue: takes up to three results per cycle, releases one on pop_i.
`timescale 1ns / 1ps

module ctcgd_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctcgd_pkg::push_t          push_i,
  input  logic                      pop_i,
  output ctcgd_pkg::result_t        head_o,
  output logic [ctcgd_pkg::FCNT_BITS-1:0] count_o
);
  import ctcgd_pkg::*;

  result_t              mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wptr_q, wptr_d;
  logic [PTR_BITS-1:0]  rptr_q, rptr_d;
  logic [FCNT_BITS-1:0] count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q + PTR_BITS'(push_i.num);
    rptr_d  = rptr_q + PTR_BITS'(pop_i);
    count_d = count_q + FCNT_BITS'(push_i.num) - FCNT_BITS'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (PUSH_BITS'(k) < push_i.num) begin
        mem_q[wptr_q + PTR_BITS'(k)] <= push_i.data[k];
      end
    end
  end

  assign head_o  = mem_q[rptr_q];
  assign count_o = count_q;

endmodule
